// ===== rtl/core/lru_key_value_cache_assert.svh =====
// Assertion macros shared by the cache modules.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define LKVC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define LKVC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/lkvc_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
package lkvc_pkg;

   localparam int unsigned CapWidth = 5;
   localparam int unsigned DataWidth = 32;
   localparam logic [CapWidth-1:0] CapReset = 5'd16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_COMMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic lookup;
      logic commit;
      logic rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_put;
   } status_type;

endpackage

// ===== rtl/core/lkvc_ctrl.sv =====
// Controller state machine that sequences one request through the datapath.
`include "lru_key_value_cache_assert.svh"

module lkvc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lkvc_pkg::cmd_type    cmd,
   input  lkvc_pkg::status_type status
);

   lkvc_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_busy;

   assign rsp_busy = rsp_valid_ff && rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lkvc_pkg::ST_IDLE: begin
            if (req_valid) state_in = lkvc_pkg::ST_LOOKUP;
         end
         lkvc_pkg::ST_LOOKUP: begin
            state_in = lkvc_pkg::ST_COMMIT;
         end
         lkvc_pkg::ST_COMMIT: begin
            // A get waits here until the output register can take its beat.
            if (status.is_put || !rsp_busy) state_in = lkvc_pkg::ST_IDLE;
         end
         default: begin
            state_in = lkvc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      cmd = '0;
      case (state_ff)
         lkvc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.capture = req_valid;
         end
         lkvc_pkg::ST_LOOKUP: begin
            cmd.lookup = 1'b1;
         end
         lkvc_pkg::ST_COMMIT: begin
            cmd.commit = status.is_put || !rsp_busy;
            cmd.rsp_load = !status.is_put && !rsp_busy;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lkvc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `LKVC_ASSERT_NEXT(a_capture_to_lookup, cmd.capture, state_ff == lkvc_pkg::ST_LOOKUP,
      "captured request did not move to lookup")
   `LKVC_ASSERT_NOW(a_rsp_only_for_get, cmd.rsp_load, !status.is_put && !rsp_busy,
      "result beat loaded for a put or over a stalled beat")

endmodule

// ===== rtl/core/lkvc_dpath.sv =====
// Datapath: key store, value memory, recency ranks and the result register.
`include "lru_key_value_cache_assert.svh"

module lkvc_dpath #(
   parameter int unsigned ENTRIES = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lkvc_pkg::cmd_type                     cmd,
   output lkvc_pkg::status_type                  status,
   input  logic                                  req_op,
   input  logic signed [lkvc_pkg::DataWidth-1:0] req_key,
   input  logic signed [lkvc_pkg::DataWidth-1:0] req_value,
   input  logic                                  cfg_write,
   input  logic [lkvc_pkg::CapWidth-1:0]         cfg_data,
   output logic                                  rsp_hit,
   output logic signed [lkvc_pkg::DataWidth-1:0] rsp_read_value
);

   localparam int unsigned RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned OW = $clog2(ENTRIES + 1);
   localparam int unsigned EW = (OW > lkvc_pkg::CapWidth) ? OW : lkvc_pkg::CapWidth;
   localparam int unsigned DW = lkvc_pkg::DataWidth;

   // Request registers.
   logic          op_ff;
   logic [DW-1:0] key_ff;
   logic [DW-1:0] val_ff;

   // Entry state.
   logic [DW-1:0]      keys_ff [ENTRIES];
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [RW-1:0]      rank_ff [ENTRIES];
   logic [RW-1:0]      rank_in [ENTRIES];
   logic [OW-1:0]      occ_ff, occ_in;
   logic [lkvc_pkg::CapWidth-1:0] cap_ff;

   // Value memory.
   logic [DW-1:0] vmem [ENTRIES];
   logic [DW-1:0] rdata_ff;

   // Lookup results.
   logic [ENTRIES-1:0] match, victim;
   logic [RW-1:0]      hit_idx, victim_idx, free_idx, rank_or;
   logic               hit_any, need_evict;
   logic [OW-1:0]      occ_last;
   logic [EW-1:0]      eff_cap;
   logic               hit_ff;
   logic               evict_ff;
   logic [RW-1:0]      idx_ff;
   logic [RW-1:0]      hit_rank_ff;

   // Result register.
   logic          rsp_hit_ff;
   logic [DW-1:0] rsp_value_ff;

   assign status.is_put = op_ff;

   // Parallel key compare and least-recent search; valid ranks are always
   // a permutation of zero to occupancy minus one, so the victim is unique.
   assign occ_last = occ_ff - OW'(1);

   always_comb begin
      hit_idx = '0;
      victim_idx = '0;
      free_idx = '0;
      rank_or = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         match[i] = valid_ff[i] && (keys_ff[i] == key_ff);
         victim[i] = valid_ff[i] && (OW'(rank_ff[i]) == occ_last);
         if (match[i]) hit_idx = RW'(i);
         if (victim[i]) victim_idx = RW'(i);
         if (!valid_ff[i]) free_idx = RW'(i);
         rank_or = rank_or | (rank_ff[i] & {RW{match[i]}});
      end
      hit_any = |match;
   end

   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = EW'(1);
      end else if (EW'(cap_ff) > EW'(ENTRIES)) begin
         eff_cap = EW'(ENTRIES);
      end else begin
         eff_cap = EW'(cap_ff);
      end
      need_evict = (EW'(occ_ff) >= eff_cap);
   end

   // Commit: touch on a hit, fill and age everything on a put miss.
   always_comb begin
      valid_in = valid_ff;
      occ_in = occ_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      if (cmd.commit) begin
         if (hit_ff) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (valid_ff[i] && (RW'(i) != idx_ff) && (rank_ff[i] < hit_rank_ff)) begin
                  rank_in[i] = rank_ff[i] + RW'(1);
               end
            end
            rank_in[idx_ff] = '0;
         end else if (op_ff) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (valid_ff[i] && (RW'(i) != idx_ff)) begin
                  rank_in[i] = rank_ff[i] + RW'(1);
               end
            end
            rank_in[idx_ff] = '0;
            valid_in[idx_ff] = 1'b1;
            if (!evict_ff) occ_in = occ_ff + OW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff <= '0;
         cap_ff <= lkvc_pkg::CapReset;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         occ_ff <= occ_in;
         if (cfg_write) cap_ff <= cfg_data;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_op;
         key_ff <= req_key;
         val_ff <= req_value;
      end
      if (cmd.lookup) begin
         hit_ff <= hit_any;
         evict_ff <= need_evict;
         hit_rank_ff <= rank_or;
         if (hit_any) begin
            idx_ff <= hit_idx;
         end else if (need_evict) begin
            idx_ff <= victim_idx;
         end else begin
            idx_ff <= free_idx;
         end
      end
      if (cmd.commit && op_ff && !hit_ff) begin
         keys_ff[idx_ff] <= key_ff;
      end
      if (cmd.rsp_load) begin
         rsp_hit_ff <= hit_ff;
         rsp_value_ff <= hit_ff ? rdata_ff : '1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && op_ff) begin
         vmem[idx_ff] <= val_ff;
      end
      if (cmd.lookup) begin
         rdata_ff <= vmem[hit_idx];
      end
   end

   assign rsp_hit = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;

   `LKVC_ASSERT_NOW(a_occ_matches_valid, 1'b1, $countones(valid_ff) == 32'(occ_ff),
      "occupancy disagrees with the number of valid entries")
   `LKVC_ASSERT_NOW(a_unique_key, cmd.lookup, $countones(match) <= 1,
      "more than one entry holds the same key")
   `LKVC_ASSERT_NOW(a_one_victim, cmd.lookup && occ_ff != '0, $countones(victim) == 1,
      "least recent entry is not unique")

endmodule

// ===== rtl/core/lru_key_value_cache.sv =====
// Fully associative key-value cache with least-recently-used replacement.
//
// Requests arrive on the req_ channel (valid/stall): req_op selects get (0)
// or put (1), with req_key and, for a put, req_value. A beat is taken when
// req_valid is high and req_stall is low. Every get returns one beat on the
// rsp_ channel: rsp_hit and the stored value, or -1 on a miss. A put returns
// nothing; it updates a hit in place or fills a slot, evicting the least
// recent entry once occupancy reaches the capacity register.
// One request passes through three steps: capture, parallel key compare with
// registered value-memory read, and commit of the rank and store updates. The
// controller handles one request at a time and accepts a new one only once
// the last has committed. A get result is visible on rsp_ the cycle after
// commit. The output register lets the next request be taken while a result
// waits; if rsp_stall holds that beat, the following get waits in its commit
// cycle and req_stall stays high. The csr_ channel writes capacity_in_use (0
// reads as 1, values above the entry count saturate); the user must write it
// only while the cache is idle, and the block does not enforce this.
// Synchronous reset empties the cache at once and sets capacity to 16.
module lru_key_value_cache #(
   parameter int unsigned ENTRIES = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_op,
   input  logic signed [lkvc_pkg::DataWidth-1:0] req_key,
   input  logic signed [lkvc_pkg::DataWidth-1:0] req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_hit,
   output logic signed [lkvc_pkg::DataWidth-1:0] rsp_read_value,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lkvc_pkg::CapWidth-1:0]         csr_data
);

   lkvc_pkg::cmd_type    cmd;
   lkvc_pkg::status_type status;

   assign csr_ready = 1'b1;

   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   lkvc_dpath #(
      .ENTRIES (ENTRIES)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_op         (req_op),
      .req_key        (req_key),
      .req_value      (req_value),
      .cfg_write      (csr_valid && csr_ready),
      .cfg_data       (csr_data),
      .rsp_hit        (rsp_hit),
      .rsp_read_value (rsp_read_value)
   );

endmodule
